// ----- src/evr_pkg.sv -----
// Shared types and constants for the Euler vertex rotation block.
package evr_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int COEF_WIDTH = 16;
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;
    // two register stages per axis, three axes
    localparam int LATENCY    = 6;

    typedef enum logic [2:0] {
        REG_COS_X   = 3'd0,
        REG_SIN_X   = 3'd1,
        REG_COS_Y   = 3'd2,
        REG_SIN_Y   = 3'd3,
        REG_COS_Z   = 3'd4,
        REG_SIN_Z   = 3'd5,
        REG_AXIS_EN = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] cos_v;
        logic signed [COEF_WIDTH-1:0] sin_v;
    } coef_t;

endpackage

// ----- src/euler_vertex_rotate_top.sv -----
// Top level of the Euler vertex rotation pipeline.
// One vertex is taken on every cycle that start is high (busy never rises), and
// its rotated coordinates appear with done once it has passed through three axis
// units in series (x, then y, then z), each two register stages deep - one for
// the four coefficient products, one for the sum, rounding and saturation.
// There is no backpressure: done is a one-cycle strobe and must be taken then.
// Coefficients and enables are read live, so write them only while no vertex
// is in flight.
module euler_vertex_rotate_top
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [evr_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [evr_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [evr_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      x_in,
    input  logic signed [COORD_WIDTH-1:0]      y_in,
    input  logic signed [COORD_WIDTH-1:0]      z_in,
    input  logic                               last_in,
    output logic                               done,
    output logic signed [COORD_WIDTH-1:0]      x_out,
    output logic signed [COORD_WIDTH-1:0]      y_out,
    output logic signed [COORD_WIDTH-1:0]      z_out,
    output logic                               last_out
);

    evr_pkg::coef_t coef_x, coef_y, coef_z;
    logic [2:0]     axis_enable;
    logic           req;

    logic                          v1, v2;
    logic signed [COORD_WIDTH-1:0] x1, y1, z1, x2, y2, z2;
    logic                          l1, l2;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign req    = start && !busy;

    evr_cfg_regs u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .coef_x      (coef_x),
        .coef_y      (coef_y),
        .coef_z      (coef_z),
        .axis_enable (axis_enable)
    );

    // x axis mixes (y, z)
    evr_rot_stage #(.COORD_WIDTH(COORD_WIDTH)) u_rot_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_x),
        .en        (axis_enable[0]),
        .in_valid  (req),
        .in_a      (y_in),
        .in_b      (z_in),
        .in_c      (x_in),
        .in_last   (last_in),
        .out_valid (v1),
        .out_a     (y1),
        .out_b     (z1),
        .out_c     (x1),
        .out_last  (l1)
    );

    // y axis mixes (z, x)
    evr_rot_stage #(.COORD_WIDTH(COORD_WIDTH)) u_rot_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_y),
        .en        (axis_enable[1]),
        .in_valid  (v1),
        .in_a      (z1),
        .in_b      (x1),
        .in_c      (y1),
        .in_last   (l1),
        .out_valid (v2),
        .out_a     (z2),
        .out_b     (x2),
        .out_c     (y2),
        .out_last  (l2)
    );

    // z axis mixes (x, y)
    evr_rot_stage #(.COORD_WIDTH(COORD_WIDTH)) u_rot_z
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_z),
        .en        (axis_enable[2]),
        .in_valid  (v2),
        .in_a      (x2),
        .in_b      (y2),
        .in_c      (z2),
        .in_last   (l2),
        .out_valid (done),
        .out_a     (x_out),
        .out_b     (y_out),
        .out_c     (z_out),
        .out_last  (last_out)
    );

`ifndef ASSERT_OFF
    a_req_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        req |-> ##(evr_pkg::LATENCY) done)
        else $error("request did not complete after pipeline latency");

    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req, evr_pkg::LATENCY))
        else $error("done without a matching request");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req |-> ##(evr_pkg::LATENCY) (last_out == $past(last_in, evr_pkg::LATENCY)))
        else $error("last flag not carried with its vertex");

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (req && axis_enable == 3'd0) |-> ##(evr_pkg::LATENCY)
            (x_out == $past(x_in, evr_pkg::LATENCY)
             && y_out == $past(y_in, evr_pkg::LATENCY)
             && z_out == $past(z_in, evr_pkg::LATENCY)))
        else $error("vertex altered with all axes disabled");
`endif

endmodule

// ----- src/evr_cfg_regs.sv -----
// APB register file holding the rotation coefficients and axis enables.
module evr_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [evr_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [evr_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [evr_pkg::DATA_WIDTH-1:0]      prdata,
    output evr_pkg::coef_t                      coef_x,
    output evr_pkg::coef_t                      coef_y,
    output evr_pkg::coef_t                      coef_z,
    output logic [2:0]                          axis_enable
);

    localparam logic signed [evr_pkg::COEF_WIDTH-1:0] COEF_ONE = 16'sd16384;

    evr_pkg::coef_t   coef_x_reg;
    evr_pkg::coef_t   coef_y_reg;
    evr_pkg::coef_t   coef_z_reg;
    logic [2:0]       axis_en_reg;
    logic             wr_en;
    logic [15:0]      wdata16;
    evr_pkg::reg_idx_t idx;

    assign wr_en   = psel && penable && pwrite;
    assign wdata16 = pwdata[15:0];
    assign idx     = evr_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg  <= '{cos_v: COEF_ONE, sin_v: '0};
            coef_y_reg  <= '{cos_v: COEF_ONE, sin_v: '0};
            coef_z_reg  <= '{cos_v: COEF_ONE, sin_v: '0};
            axis_en_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                evr_pkg::REG_COS_X:   coef_x_reg.cos_v <= wdata16;
                evr_pkg::REG_SIN_X:   coef_x_reg.sin_v <= wdata16;
                evr_pkg::REG_COS_Y:   coef_y_reg.cos_v <= wdata16;
                evr_pkg::REG_SIN_Y:   coef_y_reg.sin_v <= wdata16;
                evr_pkg::REG_COS_Z:   coef_z_reg.cos_v <= wdata16;
                evr_pkg::REG_SIN_Z:   coef_z_reg.sin_v <= wdata16;
                evr_pkg::REG_AXIS_EN: axis_en_reg      <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            evr_pkg::REG_COS_X:   prdata[15:0] = coef_x_reg.cos_v;
            evr_pkg::REG_SIN_X:   prdata[15:0] = coef_x_reg.sin_v;
            evr_pkg::REG_COS_Y:   prdata[15:0] = coef_y_reg.cos_v;
            evr_pkg::REG_SIN_Y:   prdata[15:0] = coef_y_reg.sin_v;
            evr_pkg::REG_COS_Z:   prdata[15:0] = coef_z_reg.cos_v;
            evr_pkg::REG_SIN_Z:   prdata[15:0] = coef_z_reg.sin_v;
            evr_pkg::REG_AXIS_EN: prdata[2:0]  = axis_en_reg;
            default:              prdata       = '0;
        endcase
    end

    assign coef_x      = coef_x_reg;
    assign coef_y      = coef_y_reg;
    assign coef_z      = coef_z_reg;
    assign axis_enable = axis_en_reg;

endmodule

// ----- src/evr_rot_stage.sv -----
// One plane rotation: products registered, then sum, round and saturate (a and b pass through when en is low).
module evr_rot_stage
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  evr_pkg::coef_t                coef,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] in_a,
    input  logic signed [COORD_WIDTH-1:0] in_b,
    input  logic signed [COORD_WIDTH-1:0] in_c,
    input  logic                          in_last,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH-1:0] out_a,
    output logic signed [COORD_WIDTH-1:0] out_b,
    output logic signed [COORD_WIDTH-1:0] out_c,
    output logic                          out_last
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = W + evr_pkg::COEF_WIDTH;
    localparam int SW  = W + 18;
    localparam int RW  = SW - evr_pkg::FRAC_BITS;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1 << (evr_pkg::FRAC_BITS - 1));
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

    // product stage
    logic                 v1_reg;
    logic                 en1_reg;
    logic signed [MW-1:0] ca_reg, sb_reg, sa_reg, cb_reg;
    logic signed [W-1:0]  a1_reg, b1_reg, c1_reg;
    logic                 last1_reg;

    // sum stage
    logic                 v2_reg;
    logic signed [W-1:0]  a2_reg, b2_reg, c2_reg;
    logic                 last2_reg;

    logic signed [SW-1:0] sum_a, sum_b;
    logic signed [RW-1:0] sh_a, sh_b;
    logic signed [W-1:0]  sat_a, sat_b;
    logic signed [W-1:0]  a2_next, b2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg    <= MW'(in_a) * MW'(coef.cos_v);
        sb_reg    <= MW'(in_b) * MW'(coef.sin_v);
        sa_reg    <= MW'(in_a) * MW'(coef.sin_v);
        cb_reg    <= MW'(in_b) * MW'(coef.cos_v);
        a1_reg    <= in_a;
        b1_reg    <= in_b;
        c1_reg    <= in_c;
        en1_reg   <= en;
        last1_reg <= in_last;
    end

    // a' = cos*a - sin*b, b' = sin*a + cos*b
    always_comb
    begin
        sum_a = SW'(ca_reg) - SW'(sb_reg) + ROUND_HALF;
        sum_b = SW'(sa_reg) + SW'(cb_reg) + ROUND_HALF;
        sh_a  = sum_a[SW-1:evr_pkg::FRAC_BITS];
        sh_b  = sum_b[SW-1:evr_pkg::FRAC_BITS];
        if (sh_a > SAT_HI)
            sat_a = SAT_HI[W-1:0];
        else if (sh_a < SAT_LO)
            sat_a = SAT_LO[W-1:0];
        else
            sat_a = sh_a[W-1:0];
        if (sh_b > SAT_HI)
            sat_b = SAT_HI[W-1:0];
        else if (sh_b < SAT_LO)
            sat_b = SAT_LO[W-1:0];
        else
            sat_b = sh_b[W-1:0];
        a2_next = en1_reg ? sat_a : a1_reg;
        b2_next = en1_reg ? sat_b : b1_reg;
    end

    always_ff @(posedge clk)
    begin
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        c2_reg    <= c1_reg;
        last2_reg <= last1_reg;
    end

    assign out_valid = v2_reg;
    assign out_a     = a2_reg;
    assign out_b     = b2_reg;
    assign out_c     = c2_reg;
    assign out_last  = last2_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for euler_vertex_rotate_top: directed table, then randomised phases.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CW         = 24;
    localparam int     ROUND_HALF = 8192;
    localparam longint COORD_MAX  = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam int     REG_UNUSED = 7;   // index past the register file, writes must be dropped
    localparam int     NUM_PHASES = 10;
    localparam int     PHASE_LEN  = 50;

    // coefficient settings used by the directed table
    localparam int SET_RESET   = 0;
    localparam int SET_SAT     = 1;
    localparam int SET_QUARTER = 2;
    localparam int SET_MIXED   = 3;

    // coefficient draw modes for the random phases
    localparam int COEF_EXTREME = 0;
    localparam int COEF_UNIT    = 1;
    localparam int COEF_ANY     = 2;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } vertex_t;

    typedef struct {
        int      setting;
        vertex_t stim;
        bit      typed;
        vertex_t want;
    } dir_row_t;

    localparam int NUM_DIR = 18;

    // passthrough rows carry their expectation; the rest go through the predictor
    const dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{SET_RESET, '{24'h000000, 24'h000000, 24'h000000, 1'b0}, 1'b1,
                     '{24'h000000, 24'h000000, 24'h000000, 1'b0}},
        '{SET_RESET, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1}, 1'b1,
                     '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1}},
        '{SET_RESET, '{24'h800000, 24'h800000, 24'h800000, 1'b0}, 1'b1,
                     '{24'h800000, 24'h800000, 24'h800000, 1'b0}},
        '{SET_RESET, '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1}, 1'b1,
                     '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1}},
        '{SET_RESET, '{24'hFFFFFF, 24'h000001, 24'h555555, 1'b0}, 1'b1,
                     '{24'hFFFFFF, 24'h000001, 24'h555555, 1'b0}},
        '{SET_RESET, '{24'hAAAAAA, 24'h555555, 24'hFFFFFF, 1'b1}, 1'b1,
                     '{24'hAAAAAA, 24'h555555, 24'hFFFFFF, 1'b1}},
        '{SET_SAT,   '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0}, 1'b0, '{0, 0, 0, 0}},
        '{SET_SAT,   '{24'h800000, 24'h800000, 24'h800000, 1'b1}, 1'b0, '{0, 0, 0, 0}},
        '{SET_SAT,   '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0}, 1'b0, '{0, 0, 0, 0}},
        '{SET_SAT,   '{24'h800000, 24'h7FFFFF, 24'h800000, 1'b1}, 1'b0, '{0, 0, 0, 0}},
        '{SET_SAT,   '{24'h000001, 24'hFFFFFF, 24'h000000, 1'b0}, 1'b0, '{0, 0, 0, 0}},
        '{SET_SAT,   '{24'h123456, 24'hFEDCBA, 24'h0F0F0F, 1'b1}, 1'b0, '{0, 0, 0, 0}},
        '{SET_QUARTER, '{24'h100000, 24'h200000, 24'h300000, 1'b0}, 1'b0, '{0, 0, 0, 0}},
        '{SET_QUARTER, '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1}, 1'b0, '{0, 0, 0, 0}},
        '{SET_QUARTER, '{24'hFFFFFF, 24'h000001, 24'h000002, 1'b0}, 1'b0, '{0, 0, 0, 0}},
        '{SET_MIXED, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1}, 1'b0, '{0, 0, 0, 0}},
        '{SET_MIXED, '{24'h800000, 24'h000000, 24'h7FFFFF, 1'b0}, 1'b0, '{0, 0, 0, 0}},
        '{SET_MIXED, '{24'h012345, 24'hF00000, 24'h0ABCDE, 1'b1}, 1'b0, '{0, 0, 0, 0}}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [evr_pkg::ADDR_WIDTH-1:0] paddr;
    logic [evr_pkg::DATA_WIDTH-1:0] pwdata;
    logic [evr_pkg::DATA_WIDTH-1:0] prdata;
    logic                           pready;
    logic                           start;
    logic                           busy;
    logic signed [CW-1:0]           x_in;
    logic signed [CW-1:0]           y_in;
    logic signed [CW-1:0]           z_in;
    logic                           last_in;
    logic                           done;
    logic signed [CW-1:0]           x_out;
    logic signed [CW-1:0]           y_out;
    logic signed [CW-1:0]           z_out;
    logic                           last_out;

    // predictor copy of the register file
    logic signed [evr_pkg::COEF_WIDTH-1:0] coef_q [6];
    logic [2:0]                            axis_en_q;

    vertex_t pending_vertices [$];
    int      mismatch_count;
    int      vertices_done;
    int      settings_used;
    int      regs_read;

    euler_vertex_rotate_top #(
        .COORD_WIDTH (CW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .start    (start),
        .busy     (busy),
        .x_in     (x_in),
        .y_in     (y_in),
        .z_in     (z_in),
        .last_in  (last_in),
        .done     (done),
        .x_out    (x_out),
        .y_out    (y_out),
        .z_out    (z_out),
        .last_out (last_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // one output coordinate: rounded Q2.14 product sum, saturated to the coordinate width
    function automatic longint rot_term(longint c0, longint a, longint c1, longint b);
        longint acc;
        acc = (c0 * a + c1 * b + ROUND_HALF) >>> evr_pkg::FRAC_BITS;
        if (acc > COORD_MAX)
            acc = COORD_MAX;
        else if (acc < COORD_MIN)
            acc = COORD_MIN;
        return acc;
    endfunction

    function automatic vertex_t rotate_vertex(vertex_t v);
        longint  x, y, z, t;
        longint  cx, sx, cy, sy, cz, sz;
        vertex_t r;
        x  = v.x;
        y  = v.y;
        z  = v.z;
        cx = coef_q[evr_pkg::REG_COS_X];
        sx = coef_q[evr_pkg::REG_SIN_X];
        cy = coef_q[evr_pkg::REG_COS_Y];
        sy = coef_q[evr_pkg::REG_SIN_Y];
        cz = coef_q[evr_pkg::REG_COS_Z];
        sz = coef_q[evr_pkg::REG_SIN_Z];
        if (axis_en_q[0])
        begin
            t = rot_term(cx, y, -sx, z);
            z = rot_term(sx, y, cx, z);
            y = t;
        end
        if (axis_en_q[1])
        begin
            t = rot_term(cy, z, -sy, x);
            x = rot_term(sy, z, cy, x);
            z = t;
        end
        if (axis_en_q[2])
        begin
            t = rot_term(cz, x, -sz, y);
            y = rot_term(sz, x, cz, y);
            x = t;
        end
        r.x    = x[CW-1:0];
        r.y    = y[CW-1:0];
        r.z    = z[CW-1:0];
        r.last = v.last;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX[CW-1:0];
            1:       return COORD_MIN[CW-1:0];
            2:       return CW'($urandom_range(0, 2000) - 1000);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic [evr_pkg::COEF_WIDTH-1:0] pick_coef(int mode);
        logic [evr_pkg::COEF_WIDTH-1:0] pool [7];
        pool = '{16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'h0000, 16'h0001, 16'hFFFF};
        case (mode)
            COEF_EXTREME: return pool[$urandom_range(0, 6)];
            COEF_UNIT:    return evr_pkg::COEF_WIDTH'($urandom_range(0, 32768) - 16384);
            default:      return evr_pkg::COEF_WIDTH'($urandom);
        endcase
    endfunction

    task automatic write_reg(int idx, logic [evr_pkg::DATA_WIDTH-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = evr_pkg::ADDR_WIDTH'(idx * 4);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx <= int'(evr_pkg::REG_SIN_Z))
            coef_q[idx] = data[evr_pkg::COEF_WIDTH-1:0];
        else if (idx == int'(evr_pkg::REG_AXIS_EN))
            axis_en_q = data[2:0];
    endtask

    task automatic read_reg(int idx, output logic [evr_pkg::DATA_WIDTH-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = evr_pkg::ADDR_WIDTH'(idx * 4);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
    endtask

    // read every register back and compare the meaningful bits, then release the bus
    task automatic check_regs();
        logic [evr_pkg::DATA_WIDTH-1:0] got;
        for (int r = evr_pkg::REG_COS_X; r <= evr_pkg::REG_AXIS_EN; r++)
        begin
            read_reg(r, got);
            regs_read++;
            if (r == evr_pkg::REG_AXIS_EN)
            begin
                if (got[2:0] !== axis_en_q)
                    report_mismatch("axis_enable readback", got[2:0], axis_en_q);
            end
            else if (got[evr_pkg::COEF_WIDTH-1:0] !== coef_q[r])
                report_mismatch($sformatf("coefficient %0d readback", r),
                                $signed(got[evr_pkg::COEF_WIDTH-1:0]), coef_q[r]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        settings_used++;
    endtask

    task automatic write_coefs(logic [evr_pkg::COEF_WIDTH-1:0] c,
                               logic [evr_pkg::COEF_WIDTH-1:0] s,
                               logic [2:0] en);
        for (int r = evr_pkg::REG_COS_X; r <= evr_pkg::REG_SIN_Z; r += 2)
        begin
            write_reg(r,     {$urandom} & 32'hFFFF_0000 | c);
            write_reg(r + 1, {$urandom} & 32'hFFFF_0000 | s);
        end
        write_reg(evr_pkg::REG_AXIS_EN, {$urandom} & 32'hFFFF_FFF8 | en);
    endtask

    task automatic apply_setting(int id);
        case (id)
            // out-of-range coefficients drive the sums into saturation
            SET_SAT:     write_coefs(16'h7FFF, 16'h8000, 3'b111);
            SET_QUARTER: write_coefs(16'h0000, 16'h4000, 3'b111);
            SET_MIXED:
            begin
                write_coefs(16'h8000, 16'h7FFF, 3'b101);
                write_reg(REG_UNUSED, 32'hFFFF_FFFF);
            end
            default:     write_coefs(16'h4000, 16'h0000, 3'b000);
        endcase
        check_regs();
    endtask

    // block is idle once every request has come back and the pipe has emptied
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        wait (pending_vertices.size() == 0);
        repeat (evr_pkg::LATENCY + 2) @(posedge clk);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_vertex(vertex_t v, vertex_t want);
        @(negedge clk);
        start   = 1'b1;
        x_in    = v.x;
        y_in    = v.y;
        z_in    = v.z;
        last_in = v.last;
        do
            @(posedge clk);
        while (busy);
        pending_vertices.push_back(want);
    endtask

    always @(posedge clk)
    begin : result_check
        vertex_t want;
        if (rst_n && done)
        begin
            vertices_done++;
            if (pending_vertices.size() == 0)
                report_mismatch("result with no request outstanding", x_out, 0);
            else
            begin
                want = pending_vertices.pop_front();
                if (x_out !== want.x)
                    report_mismatch("x_out", x_out, want.x);
                if (y_out !== want.y)
                    report_mismatch("y_out", y_out, want.y);
                if (z_out !== want.z)
                    report_mismatch("z_out", z_out, want.z);
                if (last_out !== want.last)
                    report_mismatch("last_out", last_out, want.last);
            end
        end
    end

    initial
    begin : stimulus
        vertex_t v;
        int      cur_setting;
        int      mode;
        int      gap;
        bit      burst;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        start     = 1'b0;
        x_in      = '0;
        y_in      = '0;
        z_in      = '0;
        last_in   = 1'b0;
        rst_n     = 1'b0;
        axis_en_q = 3'b000;
        for (int r = evr_pkg::REG_COS_X; r <= evr_pkg::REG_SIN_Z; r += 2)
        begin
            coef_q[r]     = 16'sh4000;
            coef_q[r + 1] = 16'sh0000;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_regs();
        cur_setting = SET_RESET;

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].setting != cur_setting)
            begin
                settle();
                apply_setting(DIR_ROWS[i].setting);
                cur_setting = DIR_ROWS[i].setting;
            end
            v = DIR_ROWS[i].stim;
            send_vertex(v, DIR_ROWS[i].typed ? DIR_ROWS[i].want : rotate_vertex(v));
            idle_cycles(i % 3 == 2 ? 1 : 0);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            mode = (p < 2) ? COEF_EXTREME : $urandom_range(COEF_EXTREME, COEF_ANY);
            for (int r = evr_pkg::REG_COS_X; r <= evr_pkg::REG_SIN_Z; r++)
                write_reg(r, {$urandom} & 32'hFFFF_0000 | pick_coef(mode));
            write_reg(evr_pkg::REG_AXIS_EN, (p == 0) ? 32'd7 : $urandom);
            write_reg(REG_UNUSED, $urandom);
            check_regs();
            burst = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                v.x    = rand_coord();
                v.y    = rand_coord();
                v.z    = rand_coord();
                v.last = ($urandom_range(0, 7) == 0);
                send_vertex(v, rotate_vertex(v));
                gap = $urandom_range(0, 99);
                if (burst || gap < 60)
                    gap = 0;
                else if (gap < 90)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(8, 40);
                idle_cycles(gap);
            end
        end

        @(negedge clk);
        start = 1'b0;
        wait (pending_vertices.size() == 0);
        repeat (evr_pkg::LATENCY + 4) @(posedge clk);
        $display("Covered %0d vertices over %0d register settings, %0d register readbacks.",
                 vertices_done, settings_used, regs_read);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("Timed out with %0d requests outstanding", pending_vertices.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
